// File: hw/rtl/tccu_pkg.sv
`default_nettype none

package tccu_pkg;

    // input opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_SOURCE_MODE = 2'd0;
    localparam logic [1:0] CFG_TILE_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_TILE_HEIGHT = 2'd2;

    localparam int          CFG_IDX_BITS   = 2;
    localparam int          CFG_DATA_BITS  = 9;
    localparam logic [8:0]  TILE_DIM_RESET = 9'd256;
    localparam logic [3:0]  MASK_FULL      = 4'hF;
    localparam logic [3:0]  MASK_EMPTY     = 4'h0;
    localparam int          NB_COUNT       = 16;

    // neighbor search order
    localparam logic signed [2:0] NB_DX [NB_COUNT] = '{
        3'sd0, 3'sd0, 3'sd1, -3'sd1, -3'sd1, -3'sd1, 3'sd1, 3'sd1,
        3'sd0, 3'sd0, 3'sd2, -3'sd2, -3'sd2, -3'sd2, 3'sd2, 3'sd2
    };
    localparam logic signed [2:0] NB_DY [NB_COUNT] = '{
        3'sd1, -3'sd1, 3'sd0, 3'sd0, -3'sd1, 3'sd1, -3'sd1, 3'sd1,
        3'sd2, -3'sd2, 3'sd0, 3'sd0, -3'sd2, 3'sd2, -3'sd2, 3'sd2
    };

    localparam logic [2:0] BIT_COUNT [16] = '{
        3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
        3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
    };

    typedef struct packed {
        logic       op;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [3:0] coverage;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       opaque;
        logic       last;
        logic       not_ready;
    } t_out_beat;

    // tile memory word
    typedef struct packed {
        logic [3:0] mask;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_entry;

    typedef enum logic [2:0] {
        ST_LOADING,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_NB_ISSUE,
        ST_NB_CHECK,
        ST_RESCALE,
        ST_READY,
        ST_FETCH_OUT
    } t_state;

    typedef enum logic [1:0] {
        RD_FETCH,
        RD_SCAN,
        RD_NB
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_LOAD,
        WR_COPY,
        WR_RESCALE
    } t_wr_sel;

    typedef struct packed {
        logic    scan_start;
        t_rd_sel rd_sel;
        t_wr_sel wr_sel;
        logic    center_cap;
        logic    nb_inc;
        logic    scan_adv;
        logic    fetch_adv;
        logic    out_nr;
        logic    out_fetch;
    } t_dp_cmd;

    typedef struct packed {
        logic load_done;
        logic partial;
        logic mode;
        logic scan_last;
        logic nb_in;
        logic nb_final;
        logic nb_full;
        logic last_q;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: hw/rtl/tccu_ctrl.sv
`default_nettype none

module tccu_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_op,
    output logic                  o_in_stall,
    input  wire tccu_pkg::t_dp_sts i_sts,
    output tccu_pkg::t_dp_cmd     o_cmd
);

    tccu_pkg::t_state r_state, n_state;
    logic             accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tccu_pkg::ST_LOADING;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.rd_sel = tccu_pkg::RD_FETCH;
        o_cmd.wr_sel = tccu_pkg::WR_NONE;
        o_in_stall = 1'b1;
        accept     = 1'b0;

        unique case (r_state)
            tccu_pkg::ST_LOADING: begin
                // a fetch needs the output register free
                o_in_stall = (i_in_op == tccu_pkg::OP_FETCH) && !i_sts.out_free;
                accept     = i_in_valid && !o_in_stall;
                if (accept) begin
                    if (i_in_op == tccu_pkg::OP_LOAD) begin
                        o_cmd.wr_sel = tccu_pkg::WR_LOAD;
                        if (i_sts.load_done) begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = tccu_pkg::ST_SCAN_RD;
                        end
                    end else begin
                        o_cmd.out_nr = 1'b1;
                    end
                end
            end
            tccu_pkg::ST_SCAN_RD: begin
                o_cmd.rd_sel = tccu_pkg::RD_SCAN;
                n_state      = tccu_pkg::ST_SCAN_EV;
            end
            tccu_pkg::ST_SCAN_EV: begin
                if (i_sts.partial) begin
                    o_cmd.center_cap = 1'b1;
                    n_state = i_sts.mode ? tccu_pkg::ST_NB_ISSUE : tccu_pkg::ST_RESCALE;
                end else begin
                    o_cmd.scan_adv = 1'b1;
                    n_state = i_sts.scan_last ? tccu_pkg::ST_READY : tccu_pkg::ST_SCAN_RD;
                end
            end
            tccu_pkg::ST_NB_ISSUE: begin
                o_cmd.rd_sel = tccu_pkg::RD_NB;
                priority if (i_sts.nb_in) begin
                    n_state = tccu_pkg::ST_NB_CHECK;
                end else if (i_sts.nb_final) begin
                    n_state = tccu_pkg::ST_RESCALE;
                end else begin
                    o_cmd.nb_inc = 1'b1;
                end
            end
            tccu_pkg::ST_NB_CHECK: begin
                priority if (i_sts.nb_full) begin
                    o_cmd.wr_sel   = tccu_pkg::WR_COPY;
                    o_cmd.scan_adv = 1'b1;
                    n_state = i_sts.scan_last ? tccu_pkg::ST_READY : tccu_pkg::ST_SCAN_RD;
                end else if (i_sts.nb_final) begin
                    n_state = tccu_pkg::ST_RESCALE;
                end else begin
                    o_cmd.nb_inc = 1'b1;
                    n_state      = tccu_pkg::ST_NB_ISSUE;
                end
            end
            tccu_pkg::ST_RESCALE: begin
                o_cmd.wr_sel   = tccu_pkg::WR_RESCALE;
                o_cmd.scan_adv = 1'b1;
                n_state = i_sts.scan_last ? tccu_pkg::ST_READY : tccu_pkg::ST_SCAN_RD;
            end
            tccu_pkg::ST_READY: begin
                o_in_stall = (i_in_op == tccu_pkg::OP_FETCH) && !i_sts.out_free;
                accept     = i_in_valid && !o_in_stall;
                // loads are dropped here
                if (accept && (i_in_op == tccu_pkg::OP_FETCH)) begin
                    o_cmd.fetch_adv = 1'b1;
                    n_state         = tccu_pkg::ST_FETCH_OUT;
                end
            end
            tccu_pkg::ST_FETCH_OUT: begin
                o_cmd.out_fetch = 1'b1;
                n_state = i_sts.last_q ? tccu_pkg::ST_LOADING : tccu_pkg::ST_READY;
            end
            default: begin
                n_state = tccu_pkg::ST_LOADING;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/tccu_dpath.sv
`default_nettype none

module tccu_dpath #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [tccu_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [tccu_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata,
    input  wire tccu_pkg::t_in_beat                 i_in_data,
    input  wire logic                               i_out_stall,
    output logic                                    o_out_valid,
    output tccu_pkg::t_out_beat                     o_out_data,
    input  wire tccu_pkg::t_dp_cmd                  i_cmd,
    output tccu_pkg::t_dp_sts                       o_sts
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int A_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int P_BITS = $clog2(DEPTH + 1);
    localparam int W_BITS = $clog2(MAX_WIDTH + 1);
    localparam int H_BITS = $clog2(MAX_HEIGHT + 1);
    localparam int X_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int Y_BITS = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int XS     = X_BITS + 3;
    localparam int YS     = Y_BITS + 3;
    localparam int AS     = A_BITS + 3;

    // configuration
    logic       r_source_mode;
    logic [8:0] r_tile_width;
    logic [8:0] r_tile_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_mode <= 1'b0;
            r_tile_width  <= tccu_pkg::TILE_DIM_RESET;
            r_tile_height <= tccu_pkg::TILE_DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tccu_pkg::CFG_SOURCE_MODE: r_source_mode <= i_cfg_wdata[0];
                tccu_pkg::CFG_TILE_WIDTH:  r_tile_width  <= i_cfg_wdata;
                tccu_pkg::CFG_TILE_HEIGHT: r_tile_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // clamped size and tile pixel count
    logic [W_BITS-1:0]        eff_w;
    logic [H_BITS-1:0]        eff_h;
    logic [W_BITS+H_BITS-1:0] area;
    logic [P_BITS-1:0]        total;

    always_comb begin
        priority if (r_tile_width == 9'd0) begin
            eff_w = W_BITS'(1);
        end else if (32'(r_tile_width) > 32'(MAX_WIDTH)) begin
            eff_w = W_BITS'(MAX_WIDTH);
        end else begin
            eff_w = W_BITS'(r_tile_width);
        end
        priority if (r_tile_height == 9'd0) begin
            eff_h = H_BITS'(1);
        end else if (32'(r_tile_height) > 32'(MAX_HEIGHT)) begin
            eff_h = H_BITS'(MAX_HEIGHT);
        end else begin
            eff_h = H_BITS'(r_tile_height);
        end
        area  = (W_BITS + H_BITS)'(eff_w) * (W_BITS + H_BITS)'(eff_h);
        total = P_BITS'(area);
    end

    // positions
    logic [P_BITS-1:0] r_load_pos;
    logic [P_BITS-1:0] r_fetch_pos;
    logic              r_last;
    logic              fetch_last;

    assign fetch_last = (32'(r_fetch_pos) + 32'd1) >= 32'(total);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_pos  <= '0;
            r_fetch_pos <= '0;
        end else if (i_cmd.wr_sel == tccu_pkg::WR_LOAD) begin
            r_load_pos <= r_load_pos + P_BITS'(1);
        end else if (i_cmd.fetch_adv) begin
            if (fetch_last) begin
                r_load_pos  <= '0;
                r_fetch_pos <= '0;
            end else begin
                r_fetch_pos <= r_fetch_pos + P_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch_adv) begin
            r_last <= fetch_last;
        end
    end

    // completion scan registers, size latched for the whole pass
    logic [W_BITS-1:0] r_w;
    logic [H_BITS-1:0] r_h;
    logic              r_mode;
    logic [X_BITS-1:0] r_x;
    logic [Y_BITS-1:0] r_y;
    logic [A_BITS-1:0] r_idx;
    logic [3:0]        r_nb;
    tccu_pkg::t_entry  r_center;
    logic              x_end;
    logic              y_end;

    assign x_end = (32'(r_x) + 32'd1) == 32'(r_w);
    assign y_end = (32'(r_y) + 32'd1) == 32'(r_h);

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_w    <= eff_w;
            r_h    <= eff_h;
            r_mode <= r_source_mode;
            r_x    <= '0;
            r_y    <= '0;
            r_idx  <= '0;
        end else if (i_cmd.scan_adv) begin
            r_idx <= r_idx + A_BITS'(1);
            if (x_end) begin
                r_x <= '0;
                r_y <= r_y + Y_BITS'(1);
            end else begin
                r_x <= r_x + X_BITS'(1);
            end
        end
    end

    // neighbor position, bounds and address
    logic signed [2:0]    dx;
    logic signed [2:0]    dy;
    logic signed [XS-1:0] nx;
    logic signed [YS-1:0] ny;
    logic signed [AS-1:0] dyw;
    logic signed [AS-1:0] nb_sum;
    logic [A_BITS-1:0]    nb_addr;
    logic                 nb_in;

    always_comb begin
        dx = tccu_pkg::NB_DX[r_nb];
        dy = tccu_pkg::NB_DY[r_nb];
        nx = $signed(XS'(r_x)) + XS'(dx);
        ny = $signed(YS'(r_y)) + YS'(dy);
        nb_in = (nx >= 0) && (nx < $signed(XS'(r_w)))
             && (ny >= 0) && (ny < $signed(YS'(r_h)));
        unique case (dy)
            -3'sd2:  dyw = -$signed(AS'({r_w, 1'b0}));
            -3'sd1:  dyw = -$signed(AS'(r_w));
            3'sd1:   dyw = $signed(AS'(r_w));
            3'sd2:   dyw = $signed(AS'({r_w, 1'b0}));
            default: dyw = '0;
        endcase
        nb_sum  = $signed(AS'(r_idx)) + AS'(dx) + dyw;
        nb_addr = nb_sum[A_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.center_cap) begin
            r_nb <= '0;
        end else if (i_cmd.nb_inc) begin
            r_nb <= r_nb + 4'd1;
        end
    end

    // tile memory
    tccu_pkg::t_entry mem [DEPTH];
    tccu_pkg::t_entry r_rdata;
    logic [A_BITS-1:0] rd_addr;
    logic [A_BITS-1:0] wr_addr;
    tccu_pkg::t_entry  wr_data;
    logic              wr_en;

    function automatic logic [7:0] rescale(input logic [7:0] c, input logic [2:0] n);
        logic [9:0]  x4;
        logic [19:0] prod;
        logic [7:0]  q;
        x4   = {c, 2'b00};
        // divide by 3 as multiply by 683 / 2048, exact for values below 1024
        prod = 20'(x4) * 20'd683;
        unique case (n)
            3'd2:    q = x4[8:1];
            3'd3:    q = prod[18:11];
            default: q = x4[7:0];
        endcase
        return q;
    endfunction

    logic [2:0] center_n;
    assign center_n = tccu_pkg::BIT_COUNT[r_center.mask];

    always_comb begin
        unique case (i_cmd.rd_sel)
            tccu_pkg::RD_SCAN: rd_addr = r_idx;
            tccu_pkg::RD_NB:   rd_addr = nb_addr;
            default:           rd_addr = r_fetch_pos[A_BITS-1:0];
        endcase

        wr_en   = 1'b1;
        wr_addr = r_idx;
        wr_data = r_center;
        unique case (i_cmd.wr_sel)
            tccu_pkg::WR_LOAD: begin
                wr_addr       = r_load_pos[A_BITS-1:0];
                wr_data.red   = i_in_data.red;
                wr_data.green = i_in_data.green;
                wr_data.blue  = i_in_data.blue;
                wr_data.mask  = i_in_data.coverage;
            end
            tccu_pkg::WR_COPY: begin
                wr_data.red   = r_rdata.red;
                wr_data.green = r_rdata.green;
                wr_data.blue  = r_rdata.blue;
            end
            tccu_pkg::WR_RESCALE: begin
                wr_data.red   = rescale(r_center.red, center_n);
                wr_data.green = rescale(r_center.green, center_n);
                wr_data.blue  = rescale(r_center.blue, center_n);
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.center_cap) begin
            r_center <= r_rdata;
        end
    end

    // output register
    logic                r_out_valid;
    tccu_pkg::t_out_beat r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_nr || i_cmd.out_fetch) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_nr) begin
            r_out <= '{red_out: 8'd0, green_out: 8'd0, blue_out: 8'd0, opaque: 1'b0,
                       last: 1'b0, not_ready: 1'b1};
        end else if (i_cmd.out_fetch) begin
            r_out.red_out   <= r_rdata.red;
            r_out.green_out <= r_rdata.green;
            r_out.blue_out  <= r_rdata.blue;
            r_out.opaque    <= (r_rdata.mask != tccu_pkg::MASK_EMPTY);
            r_out.last      <= r_last;
            r_out.not_ready <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        o_sts.load_done = (32'(r_load_pos) + 32'd1) >= 32'(total);
        o_sts.partial   = (r_rdata.mask != tccu_pkg::MASK_EMPTY)
                       && (r_rdata.mask != tccu_pkg::MASK_FULL);
        o_sts.mode      = r_mode;
        o_sts.scan_last = x_end && y_end;
        o_sts.nb_in     = nb_in;
        o_sts.nb_final  = (r_nb == 4'(tccu_pkg::NB_COUNT - 1));
        o_sts.nb_full   = (r_rdata.mask == tccu_pkg::MASK_FULL);
        o_sts.last_q    = r_last;
        o_sts.out_free  = !r_out_valid || !i_out_stall;
    end

endmodule

`default_nettype wire

// File: hw/rtl/tile_coverage_completion_unit.sv
// Channel   Direction  Handshake            Beat
// in        input      i_in_valid/o_in_stall   tccu_pkg::t_in_beat (op, rgb, coverage)
// out       output     o_out_valid/i_out_stall tccu_pkg::t_out_beat (rgb, opaque, last, not_ready)
// cfg       input      i_cfg_we             i_cfg_index, i_cfg_wdata
//
// Load: one beat per cycle. Fetch: the result passes the tile memory read register and then
// the output register, and no new fetch is taken before it is out; a not_ready answer goes
// straight to the output register. The tile memory has a single read port. The load that
// fills the tile starts a completion pass: a full or empty pixel is kept, a partial one is
// rescaled or, in source mode, given the colour of the first fully covered neighbor inside
// the tile in search order, else rescaled. Reset is synchronous, tile memory not cleared.
// Input stalls during the pass, a fetch also while the output register holds a stalled result.
`default_nettype none

module tile_coverage_completion_unit #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [tccu_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [tccu_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire tccu_pkg::t_in_beat                 i_in_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output tccu_pkg::t_out_beat                     o_out_data
);

    tccu_pkg::t_dp_cmd cmd;
    tccu_pkg::t_dp_sts sts;

    tccu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_op    (i_in_data.op),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tccu_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

`default_nettype wire

// File: hw/rtl/tccu_checker.sv
`default_nettype none

module tccu_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_cfg_we,
    input wire logic [tccu_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input wire logic [tccu_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata,
    input wire logic                               i_in_valid,
    input wire logic                               o_in_stall,
    input wire tccu_pkg::t_in_beat                 i_in_data,
    input wire logic                               o_out_valid,
    input wire logic                               i_out_stall,
    input wire tccu_pkg::t_out_beat                o_out_data
);

    logic fetch_acc;
    assign fetch_acc = i_in_valid && !o_in_stall && (i_in_data.op == tccu_pkg::OP_FETCH);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // a not_ready result carries nothing else
    a_nr_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.not_ready |->
            (o_out_data.red_out == 8'd0) && (o_out_data.green_out == 8'd0)
            && (o_out_data.blue_out == 8'd0) && !o_out_data.opaque && !o_out_data.last)
        else $error("not_ready result with data");

    // every new result comes from an earlier accepted fetch
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(fetch_acc) || $past(fetch_acc, 2))
        else $error("result without fetch");

    // no fetch taken while the output register is blocked
    a_fetch_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall && i_in_valid && (i_in_data.op == tccu_pkg::OP_FETCH)
            |-> o_in_stall)
        else $error("fetch accepted over a blocked result");

endmodule

bind tile_coverage_completion_unit tccu_checker u_tccu_checker (.*);

`default_nettype wire
